[hdl/rsl_pkg.sv]
// Shared types, constants and the CORDIC angle table of the rate steering law core.
package rsl_pkg;

	typedef struct packed {
		logic signed [31:0] err_x;
		logic signed [31:0] err_y;
		logic signed [31:0] err_z;
	} rsl_in_t;

	typedef struct packed {
		logic signed [31:0] rate_x;
		logic signed [31:0] rate_y;
		logic signed [31:0] rate_z;
		logic signed [31:0] rate_deriv_x;
		logic signed [31:0] rate_deriv_y;
		logic signed [31:0] rate_deriv_z;
	} rsl_out_t;

	typedef enum logic [1:0] {
		CFG_GAIN_LINEAR = 2'd0,
		CFG_GAIN_CUBIC  = 2'd1,
		CFG_RATE_LIMIT  = 2'd2,
		CFG_SKIP_FF     = 2'd3
	} rsl_cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] s;
		logic [33:0]        sq;
		logic               uz;
		logic               ovf;
		logic [60:0]        x0;
		logic [30:0]        frac;
	} rsl_side_t;

	localparam int CORDIC_STEPS = 31;
	localparam int DIV_STEPS    = 31;
	localparam int AXIS_LAT     = 6 + CORDIC_STEPS + 3 + DIV_STEPS + 3;
	localparam int MIX_LAT      = 6;
	localparam int PIPE_LAT     = 1 + AXIS_LAT + MIX_LAT;

	localparam logic [24:0] Q24_PI_HALF     = 25'd26353589;
	localparam logic [30:0] Q30_PI_HALF     = 31'd1686629713;
	localparam logic [30:0] Q30_ONE         = 31'd1073741824;
	localparam logic [30:0] Q30_CORDIC_GAIN = 31'd1768195360;
	localparam logic [5:0]  NORM_MSB        = 6'd60;

	localparam logic [31:0] RESET_GAIN_LINEAR = 32'd16777216;
	localparam logic [31:0] RESET_GAIN_CUBIC  = 32'd0;
	localparam logic [31:0] RESET_RATE_LIMIT  = 32'd268435456;

	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'd843314857;
			5'd1: r = 32'd497837829;
			5'd2: r = 32'd263043837;
			5'd3: r = 32'd133525159;
			5'd4: r = 32'd67021687;
			5'd5: r = 32'd33543516;
			5'd6: r = 32'd16775851;
			5'd7: r = 32'd8388437;
			5'd8: r = 32'd4194283;
			5'd9: r = 32'd2097149;
			default: r = 32'd1 << (5'd30 - idx);
		endcase
		return r;
	endfunction

endpackage

[hdl/rsl_cordic_cell.sv]
// One vectoring CORDIC micro-rotation with its output register.
module rsl_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic [63:0]        x_i,
	input  logic [63:0]        y_i,
	input  logic signed [32:0] z_i,
	output logic [63:0]        x_o,
	output logic [63:0]        y_o,
	output logic signed [32:0] z_o
);

	localparam logic [31:0] ANGLE = rsl_pkg::atan_entry(5'(STEP));

	logic [63:0]        xs;
	logic [63:0]        ys;
	logic [63:0]        x_n;
	logic [63:0]        y_n;
	logic signed [32:0] z_n;
	logic [63:0]        x_s1;
	logic [63:0]        y_s1;
	logic signed [32:0] z_s1;

	always_comb begin
		xs = x_i >> STEP;
		ys = 64'($signed(y_i) >>> STEP);
		if (!y_i[63]) begin
			x_n = x_i + ys;
			y_n = y_i - xs;
			z_n = z_i + $signed({1'b0, ANGLE});
		end else begin
			x_n = x_i - ys;
			y_n = y_i + xs;
			z_n = z_i - $signed({1'b0, ANGLE});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_n;
			y_s1 <= y_n;
			z_s1 <= z_n;
		end
	end

	assign x_o = x_s1;
	assign y_o = y_s1;
	assign z_o = z_s1;

endmodule

[hdl/rsl_div_cell.sv]
// One restoring division step, giving one quotient bit, with its output register.
module rsl_div_cell #(
	parameter int STEP = 0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [33:0] rem_i,
	input  logic [30:0] lo_i,
	input  logic [33:0] d_i,
	input  logic [30:0] q_i,
	output logic [33:0] rem_o,
	output logic [30:0] lo_o,
	output logic [33:0] d_o,
	output logic [30:0] q_o
);

	logic [34:0] trial;
	logic        ge;
	logic [33:0] rem_n;
	logic [33:0] rem_s1;
	logic [30:0] lo_s1;
	logic [33:0] d_s1;
	logic [30:0] q_s1;

	always_comb begin
		trial = {rem_i, lo_i[30 - STEP]};
		ge    = trial >= {1'b0, d_i};
		rem_n = ge ? 34'(trial - {1'b0, d_i}) : trial[33:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= rem_n;
			lo_s1  <= lo_i;
			d_s1   <= d_i;
			q_s1   <= {q_i[29:0], ge};
		end
	end

	assign rem_o = rem_s1;
	assign lo_o  = lo_s1;
	assign d_o   = d_s1;
	assign q_o   = q_s1;

endmodule

[hdl/rsl_axis.sv]
// Per-axis pipeline: error magnitude, CORDIC arctangent, cosine squared and commanded rate.
module rsl_axis (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] err,
	input  logic [31:0]        k1,
	input  logic [31:0]        k3,
	input  logic [31:0]        wl,
	output logic signed [31:0] s_o,
	output logic [33:0]        sq_o,
	output logic signed [31:0] w_o,
	output logic [30:0]        c2_o
);

	localparam int CS = rsl_pkg::CORDIC_STEPS;
	localparam int DS = rsl_pkg::DIV_STEPS;
	localparam logic [63:0] RECIP_FULL = (64'd1 << 61) / 64'(rsl_pkg::Q30_PI_HALF);
	localparam logic [30:0] FRAC_RECIP = RECIP_FULL[30:0];

	// Stage 1: magnitude, square and linear term.
	logic [31:0]       a_c;
	logic [63:0]       sqp;
	logic [63:0]       linp;
	rsl_pkg::rsl_side_t side1_c;
	logic [31:0]       a_s1;
	logic [34:0]       lin_s1;
	rsl_pkg::rsl_side_t side_s1;

	always_comb begin
		a_c  = err[31] ? 32'(-err) : 32'(err);
		sqp  = 64'(a_c) * 64'(a_c);
		linp = 64'(k1) * 64'(a_c);
		side1_c    = '0;
		side1_c.s  = err;
		side1_c.sq = sqp[62:29];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a_c;
			lin_s1  <= linp[63:29];
			side_s1 <= side1_c;
		end
	end

	// Stage 2: cube.
	logic [64:0]       a3p;
	logic [35:0]       a3_s2;
	logic [34:0]       lin_s2;
	rsl_pkg::rsl_side_t side_s2;

	assign a3p = 65'(side_s1.sq) * 65'(a_s1[31:1]);

	always_ff @(posedge clk) begin
		if (en) begin
			a3_s2   <= a3p[63:28];
			lin_s2  <= lin_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: atan argument.
	logic [62:0]       cubp;
	logic [39:0]       u_s3;
	rsl_pkg::rsl_side_t side_s3;

	assign cubp = 63'(k3) * 63'(a3_s2[35:5]);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s3    <= 40'(lin_s2) + 40'(cubp[62:24]);
			side_s3 <= side_s2;
		end
	end

	// Stage 4: CORDIC start vector.
	logic [64:0]       yp;
	rsl_pkg::rsl_side_t side4_c;
	logic [63:0]       x_s4;
	logic [63:0]       y_s4;
	rsl_pkg::rsl_side_t side_s4;

	assign yp = 65'(u_s3) * 65'(rsl_pkg::Q24_PI_HALF);

	always_comb begin
		side4_c    = side_s3;
		side4_c.uz = u_s3 == 40'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= {12'd0, wl, 20'd0};
			y_s4    <= yp[63:0];
			side_s4 <= side4_c;
		end
	end

	// Stage 5: leading one search.
	logic [63:0]       m_c;
	logic [5:0]        p_c;
	logic [63:0]       x_s5;
	logic [63:0]       y_s5;
	logic [5:0]        p_s5;
	rsl_pkg::rsl_side_t side_s5;

	always_comb begin
		m_c = (x_s4 > y_s4) ? x_s4 : y_s4;
		p_c = 6'd0;
		for (int k = 0; k < 64; k++) begin
			if (m_c[k]) begin
				p_c = 6'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			p_s5    <= p_c;
			side_s5 <= side_s4;
		end
	end

	// Stage 6: normalise.
	logic [63:0]       xn_c;
	logic [63:0]       yn_c;
	rsl_pkg::rsl_side_t side6_c;
	logic [63:0]       x_s6;
	logic [63:0]       y_s6;
	rsl_pkg::rsl_side_t side_s6;

	always_comb begin
		if (p_s5 > rsl_pkg::NORM_MSB) begin
			xn_c = x_s5 >> (p_s5 - rsl_pkg::NORM_MSB);
			yn_c = y_s5 >> (p_s5 - rsl_pkg::NORM_MSB);
		end else begin
			xn_c = x_s5 << (rsl_pkg::NORM_MSB - p_s5);
			yn_c = y_s5 << (rsl_pkg::NORM_MSB - p_s5);
		end
		side6_c    = side_s5;
		side6_c.x0 = xn_c[60:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6    <= xn_c;
			y_s6    <= yn_c;
			side_s6 <= side6_c;
		end
	end

	// CORDIC chain.
	logic [63:0]        cx [CS + 1];
	logic [63:0]        cy [CS + 1];
	logic signed [32:0] cz [CS + 1];
	rsl_pkg::rsl_side_t side_cq [CS];

	assign cx[0] = x_s6;
	assign cy[0] = y_s6;
	assign cz[0] = '0;

	for (genvar g = 0; g < CS; g++) begin : g_cordic
		rsl_cordic_cell #(.STEP(g)) u_cell (
			.clk (clk),
			.en  (en),
			.x_i (cx[g]),
			.y_i (cy[g]),
			.z_i (cz[g]),
			.x_o (cx[g + 1]),
			.y_o (cy[g + 1]),
			.z_o (cz[g + 1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_cq[0] <= side_s6;
			for (int k = 1; k < CS; k++) begin
				side_cq[k] <= side_cq[k - 1];
			end
		end
	end

	// Stage 38: angle clamp, reciprocal product, divisor.
	logic [30:0]       zc_c;
	logic [33:0]       d_c;
	rsl_pkg::rsl_side_t side38_c;
	logic [30:0]       zc_s38;
	logic [61:0]       zr_s38;
	logic [33:0]       d_s38;
	logic [33:0]       rem0_s38;
	logic [30:0]       lo_s38;
	rsl_pkg::rsl_side_t side_s38;

	always_comb begin
		if (cz[CS] < 33'sd0) begin
			zc_c = '0;
		end else if (cz[CS] > $signed({2'b00, rsl_pkg::Q30_PI_HALF})) begin
			zc_c = rsl_pkg::Q30_PI_HALF;
		end else begin
			zc_c = cz[CS][30:0];
		end
		d_c = cx[CS][63:30];
		if (d_c == 34'd0) begin
			d_c = 34'd1;
		end
		side38_c     = side_cq[CS - 1];
		side38_c.ovf = {4'd0, side_cq[CS - 1].x0[60:31]} >= d_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zc_s38   <= zc_c;
			zr_s38   <= 62'(zc_c) * 62'(FRAC_RECIP);
			d_s38    <= d_c;
			rem0_s38 <= {4'd0, side_cq[CS - 1].x0[60:31]};
			lo_s38   <= side_cq[CS - 1].x0[30:0];
			side_s38 <= side38_c;
		end
	end

	// Stage 39: quotient estimate times divisor.
	logic [30:0]       q0_c;
	logic [30:0]       zc_s39;
	logic [30:0]       q0_s39;
	logic [61:0]       qd_s39;
	logic [33:0]       d_s39;
	logic [33:0]       rem0_s39;
	logic [30:0]       lo_s39;
	rsl_pkg::rsl_side_t side_s39;

	assign q0_c = zr_s38[61:31];

	always_ff @(posedge clk) begin
		if (en) begin
			zc_s39   <= zc_s38;
			q0_s39   <= q0_c;
			qd_s39   <= 62'(q0_c) * 62'(rsl_pkg::Q30_PI_HALF);
			d_s39    <= d_s38;
			rem0_s39 <= rem0_s38;
			lo_s39   <= lo_s38;
			side_s39 <= side_s38;
		end
	end

	// Stage 40: quotient correction.
	logic [61:0]       fr_rem;
	rsl_pkg::rsl_side_t side40_c;
	logic [33:0]       d_s40;
	logic [33:0]       rem0_s40;
	logic [30:0]       lo_s40;
	rsl_pkg::rsl_side_t side_s40;

	assign fr_rem = {1'b0, zc_s39, 30'd0} - qd_s39;

	always_comb begin
		side40_c      = side_s39;
		side40_c.frac = (fr_rem >= 62'(rsl_pkg::Q30_PI_HALF)) ?
			31'(q0_s39 + 31'd1) : q0_s39;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s40    <= d_s39;
			rem0_s40 <= rem0_s39;
			lo_s40   <= lo_s39;
			side_s40 <= side40_c;
		end
	end

	// Divider chain.
	logic [33:0] dr [DS + 1];
	logic [30:0] dl [DS + 1];
	logic [33:0] dd [DS + 1];
	logic [30:0] dq [DS + 1];
	rsl_pkg::rsl_side_t side_dq [DS];

	assign dr[0] = rem0_s40;
	assign dl[0] = lo_s40;
	assign dd[0] = d_s40;
	assign dq[0] = '0;

	for (genvar g = 0; g < DS; g++) begin : g_div
		rsl_div_cell #(.STEP(g)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (dr[g]),
			.lo_i  (dl[g]),
			.d_i   (dd[g]),
			.q_i   (dq[g]),
			.rem_o (dr[g + 1]),
			.lo_o  (dl[g + 1]),
			.d_o   (dd[g + 1]),
			.q_o   (dq[g + 1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dq[0] <= side_s40;
			for (int k = 1; k < DS; k++) begin
				side_dq[k] <= side_dq[k - 1];
			end
		end
	end

	// Stage 72: cosine and rate magnitude products.
	rsl_pkg::rsl_side_t side_d;
	logic [30:0]       qc_c;
	logic [30:0]       fr_c;
	logic [61:0]       cm_s72;
	logic [62:0]       mp_s72;
	rsl_pkg::rsl_side_t side_s72;

	always_comb begin
		side_d = side_dq[DS - 1];
		if (side_d.ovf || dq[DS] > rsl_pkg::Q30_ONE) begin
			qc_c = rsl_pkg::Q30_ONE;
		end else begin
			qc_c = dq[DS];
		end
		fr_c = side_d.uz ? 31'd0 : side_d.frac;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s72   <= 62'(qc_c) * 62'(rsl_pkg::Q30_CORDIC_GAIN);
			mp_s72   <= 63'(wl) * 63'(fr_c);
			side_s72 <= side_d;
		end
	end

	// Stage 73: cosine squared and signed rate.
	logic [31:0]        c32_c;
	logic [30:0]        cl_c;
	logic [31:0]        mag32_c;
	logic [30:0]        mag_c;
	logic signed [31:0] w_c;
	logic [61:0]        cc_s73;
	logic signed [31:0] w_s73;
	rsl_pkg::rsl_side_t side_s73;

	always_comb begin
		c32_c   = cm_s72[61:30];
		cl_c    = (c32_c > 32'(rsl_pkg::Q30_ONE)) ? rsl_pkg::Q30_ONE : c32_c[30:0];
		mag32_c = mp_s72[62:31];
		mag_c   = (mag32_c > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : mag32_c[30:0];
		w_c     = side_s72.s[31] ? $signed({1'b0, mag_c}) : -$signed({1'b0, mag_c});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s73   <= 62'(cl_c) * 62'(cl_c);
			w_s73    <= w_c;
			side_s73 <= side_s72;
		end
	end

	// Stage 74: axis outputs.
	logic signed [31:0] s_s74;
	logic [33:0]        sq_s74;
	logic signed [31:0] w_s74;
	logic [30:0]        c2_s74;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s74  <= side_s73.s;
			sq_s74 <= side_s73.sq;
			w_s74  <= w_s73;
			c2_s74 <= side_s73.uz ? rsl_pkg::Q30_ONE : cc_s73[60:30];
		end
	end

	assign s_o  = s_s74;
	assign sq_o = sq_s74;
	assign w_o  = w_s74;
	assign c2_o = c2_s74;

endmodule

[hdl/mrp_rate_steering_law_core.sv]
// Throughput: one beat per cycle; the pipeline stalls as a whole only while a result waits.
// The depth is set by the 31-cell CORDIC chain and the 31-cell divider chain of each axis.
// Reset clears the valid pipeline and sets the config registers to their defaults.
// Top level of the rate steering law: config registers, three axis pipelines and mixing.
module mrp_rate_steering_law_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  rsl_pkg::rsl_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rsl_pkg::rsl_out_t out_data
);

	localparam int LAT = rsl_pkg::PIPE_LAT;
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	logic [31:0] gain_linear_q;
	logic [31:0] gain_cubic_q;
	logic [31:0] rate_limit_q;
	logic        skip_ff_q;
	logic [31:0] wl;
	logic        adv;
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_linear_q <= rsl_pkg::RESET_GAIN_LINEAR;
			gain_cubic_q  <= rsl_pkg::RESET_GAIN_CUBIC;
			rate_limit_q  <= rsl_pkg::RESET_RATE_LIMIT;
			skip_ff_q     <= 1'b0;
		end else if (cfg_wen) begin
			case (rsl_pkg::rsl_cfg_idx_t'(cfg_index))
				rsl_pkg::CFG_GAIN_LINEAR: gain_linear_q <= cfg_wdata;
				rsl_pkg::CFG_GAIN_CUBIC:  gain_cubic_q  <= cfg_wdata;
				rsl_pkg::CFG_RATE_LIMIT:  rate_limit_q  <= cfg_wdata;
				rsl_pkg::CFG_SKIP_FF:     skip_ff_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign wl  = (rate_limit_q == 32'd0) ? 32'd1 : rate_limit_q;
	assign adv = !vld_q[LAT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	rsl_pkg::rsl_in_t in_s0;

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s0 <= in_data;
		end
	end

	logic signed [31:0] err_c [3];
	logic signed [31:0] s_a [3];
	logic [33:0]        sq_a [3];
	logic signed [31:0] w_a [3];
	logic [30:0]        c2_a [3];

	assign err_c[0] = in_s0.err_x;
	assign err_c[1] = in_s0.err_y;
	assign err_c[2] = in_s0.err_z;

	for (genvar g = 0; g < 3; g++) begin : g_axis
		rsl_axis u_axis (
			.clk  (clk),
			.en   (adv),
			.err  (err_c[g]),
			.k1   (gain_linear_q),
			.k3   (gain_cubic_q),
			.wl   (wl),
			.s_o  (s_a[g]),
			.sq_o (sq_a[g]),
			.w_o  (w_a[g]),
			.c2_o (c2_a[g])
		);
	end

	// Stage 75: products of error and rate, sum of squares, cubic gain term.
	logic signed [63:0] pii_c [3];
	logic signed [63:0] pj_c [3];
	logic signed [63:0] pk_c [3];
	logic [56:0]        tgp_c [3];
	logic signed [34:0] swt_s75 [3];
	logic signed [34:0] pj_s75 [3];
	logic signed [34:0] pk_s75 [3];
	logic [36:0]        tg_s75 [3];
	logic [35:0]        ss_s75;
	logic signed [31:0] s_s75 [3];
	logic signed [31:0] w_s75 [3];
	logic [30:0]        c2_s75 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pii_c[i] = 64'(s_a[i]) * 64'(w_a[i]);
			pj_c[i]  = 64'(s_a[NXT[i]]) * 64'(w_a[PRV[i]]);
			pk_c[i]  = 64'(s_a[PRV[i]]) * 64'(w_a[NXT[i]]);
			tgp_c[i] = 57'(gain_cubic_q) * 57'(sq_a[i][33:9]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				swt_s75[i] <= 35'(pii_c[i] >>> 29);
				pj_s75[i]  <= 35'(pj_c[i] >>> 29);
				pk_s75[i]  <= 35'(pk_c[i] >>> 29);
				tg_s75[i]  <= tgp_c[i][56:20];
				s_s75[i]   <= s_a[i];
				w_s75[i]   <= w_a[i];
				c2_s75[i]  <= c2_a[i];
			end
			ss_s75 <= 36'(sq_a[0]) + 36'(sq_a[1]) + 36'(sq_a[2]);
		end
	end

	// Stage 76: dot product, diagonal factor, cross product, gain slope.
	logic signed [36:0] sw_c;
	logic signed [36:0] diag_c;
	logic signed [32:0] sw4_s76;
	logic signed [32:0] amul_s76;
	logic signed [35:0] cr_s76 [3];
	logic [39:0]        g_s76 [3];
	logic signed [31:0] s_s76 [3];
	logic signed [31:0] w_s76 [3];
	logic [30:0]        c2_s76 [3];

	always_comb begin
		sw_c   = 37'(swt_s75[0]) + 37'(swt_s75[1]) + 37'(swt_s75[2]);
		diag_c = $signed(37'd536870912) - $signed({1'b0, ss_s75});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sw4_s76  <= 33'(sw_c >>> 4);
			amul_s76 <= 33'(diag_c >>> 4);
			for (int i = 0; i < 3; i++) begin
				cr_s76[i] <= 36'(pj_s75[i]) - 36'(pk_s75[i]);
				g_s76[i]  <= 40'(40'(tg_s75[i]) * 40'd3) + 40'(gain_linear_q);
				s_s76[i]  <= s_s75[i];
				w_s76[i]  <= w_s75[i];
				c2_s76[i] <= c2_s75[i];
			end
		end
	end

	// Stage 77: matrix terms and derivative gain.
	logic signed [64:0] pa_c [3];
	logic signed [64:0] pb_c [3];
	logic [62:0]        ph_c [3];
	logic signed [39:0] t1_s77 [3];
	logic signed [39:0] t2_s77 [3];
	logic signed [35:0] cr_s77 [3];
	logic [40:0]        hh_s77 [3];
	logic signed [31:0] w_s77 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pa_c[i] = 65'(amul_s76) * 65'(w_s76[i]);
			pb_c[i] = 65'(s_s76[i]) * 65'(sw4_s76);
			ph_c[i] = 63'(g_s76[i][39:8]) * 63'(c2_s76[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				t1_s77[i] <= 40'(pa_c[i] >>> 25);
				t2_s77[i] <= 40'(pb_c[i] >>> 25);
				cr_s77[i] <= cr_s76[i];
				hh_s77[i] <= 41'(ph_c[i][62:22]);
				w_s77[i]  <= w_s76[i];
			end
		end
	end

	// Stage 78: error rate and its magnitude.
	logic signed [42:0] bw_c [3];
	logic signed [40:0] sd_c [3];
	logic [40:0]        mag_s78 [3];
	logic               neg_s78 [3];
	logic [40:0]        hh_s78 [3];
	logic signed [31:0] w_s78 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bw_c[i] = 43'(t1_s77[i]) + 43'(cr_s77[i]) + 43'(cr_s77[i])
				+ 43'(t2_s77[i]) + 43'(t2_s77[i]);
			sd_c[i] = 41'(bw_c[i] >>> 2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s78[i] <= sd_c[i][40];
				mag_s78[i] <= sd_c[i][40] ? 41'(-sd_c[i]) : 41'(sd_c[i]);
				hh_s78[i]  <= hh_s77[i];
				w_s78[i]   <= w_s77[i];
			end
		end
	end

	// Stage 79: partial products of gain and magnitude.
	logic [60:0]        p0_s79 [3];
	logic [61:0]        p1_s79 [3];
	logic               neg_s79 [3];
	logic signed [31:0] w_s79 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p0_s79[i]  <= 61'(hh_s78[i]) * 61'(mag_s78[i][19:0]);
				p1_s79[i]  <= 62'(hh_s78[i]) * 62'(mag_s78[i][40:20]);
				neg_s79[i] <= neg_s78[i];
				w_s79[i]   <= w_s78[i];
			end
		end
	end

	// Stage 80: saturation, or zero when feed-forward is skipped, into the output register.
	logic [82:0]        prod_c [3];
	logic [58:0]        r_c [3];
	logic signed [31:0] wp_c [3];
	rsl_pkg::rsl_out_t  out_s80;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = 83'(p0_s79[i]) + (83'(p1_s79[i]) << 20);
			r_c[i]    = prod_c[i][82:24];
			if (skip_ff_q) begin
				wp_c[i] = '0;
			end else if (neg_s79[i]) begin
				wp_c[i] = (r_c[i] > 59'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_c[i][31:0]);
			end else if (r_c[i] > 59'h8000_0000) begin
				wp_c[i] = 32'sh8000_0000;
			end else begin
				wp_c[i] = 32'(-$signed(r_c[i][31:0]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s80.rate_x       <= w_s79[0];
			out_s80.rate_y       <= w_s79[1];
			out_s80.rate_z       <= w_s79[2];
			out_s80.rate_deriv_x <= wp_c[0];
			out_s80.rate_deriv_y <= wp_c[1];
			out_s80.rate_deriv_z <= wp_c[2];
		end
	end

	assign out_data = out_s80;

endmodule
